// ===== sv/sha256_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants, initial hash value and the SHA-256 logic
// functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef enum logic [2:0] {
    StIdle,
    StRound,
    StUpdate,
    StPad,
    StDigest
  } state_e;

  // Control from the sequencer to the schedule window and the round core.
  typedef struct packed {
    logic push;     // shift one word into the block window
    logic load;     // copy chain words into the working variables
    logic step;     // run one compression round
    logic update;   // fold working variables into the chain words
    logic restart;  // return the chain words to the initial hash value
  } core_ctrl_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] PadMarkWord = 32'h80000000;
  localparam logic [7:0]  PadByte     = 8'h80;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage
`default_nettype wire

// ===== sv/sha256_sched.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 message schedule window
// A 16-word shift line that collects the block and then expands the schedule
// one word per round.
// ----------------------------------------------------------------------------
module sha256_sched (
  input  wire logic                   clk_i,
  input  wire sha256_pkg::core_ctrl_t ctrl_i,
  input  wire logic [31:0]            push_word_i,
  output logic      [31:0]            sched_word_o
);

  logic [31:0] win_q [16];
  logic [31:0] expand_word;

  // The next schedule word, computed from the taps of the window.
  assign expand_word = sha256_pkg::small_sigma1(win_q[14]) + win_q[9]
                     + sha256_pkg::small_sigma0(win_q[1]) + win_q[0];

  assign sched_word_o = win_q[0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push || ctrl_i.step) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= ctrl_i.push ? push_word_i : expand_word;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sha256_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 round core
// Holds the chain words and the working variables and runs one compression
// round per cycle while step is asserted.
// ----------------------------------------------------------------------------
module sha256_core (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire sha256_pkg::core_ctrl_t ctrl_i,
  input  wire logic [31:0]            round_k_i,
  input  wire logic [31:0]            sched_word_i,
  output logic      [255:0]           digest_o
);

  logic [31:0] chain_q [8];
  logic [31:0] var_q   [8];
  logic [31:0] t1;
  logic [31:0] t2;

  assign t1 = var_q[7] + sha256_pkg::big_sigma1(var_q[4])
            + sha256_pkg::choose(var_q[4], var_q[5], var_q[6]) + round_k_i + sched_word_i;
  assign t2 = sha256_pkg::big_sigma0(var_q[0])
            + sha256_pkg::majority(var_q[0], var_q[1], var_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= sha256_pkg::InitHash[i];
      end
    end else if (ctrl_i.restart) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= sha256_pkg::InitHash[i];
      end
    end else if (ctrl_i.update) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= chain_q[i] + var_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      for (int i = 0; i < 8; i++) begin
        var_q[i] <= chain_q[i];
      end
    end else if (ctrl_i.step) begin
      var_q[0] <= t1 + t2;
      var_q[1] <= var_q[0];
      var_q[2] <= var_q[1];
      var_q[3] <= var_q[2];
      var_q[4] <= var_q[3] + t1;
      var_q[5] <= var_q[4];
      var_q[6] <= var_q[5];
      var_q[7] <= var_q[6];
    end
  end

  assign digest_o = {chain_q[0], chain_q[1], chain_q[2], chain_q[3],
                     chain_q[4], chain_q[5], chain_q[6], chain_q[7]};

endmodule
`default_nettype wire

// ===== sv/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Input: beats are taken only while idle; after every 16th beat the input stalls through
//   the block's rounds and chain update. After the last beat, up to 15 pad words
//   (18 when the length spills into a new block) enter one per cycle; each filled block runs
//   its rounds and chain update. The digest register loads in the digest state after the
//   last chain update, or later while the previous digest is held.
// Reset: asynchronous, active low; chain to the initial value, counts and valid cleared.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a message given as big-endian 32-bit beats and emits the 256-bit
// digest after the beat marked last.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // Input channel
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [31:0]   data_word_i,
  input  wire logic [2:0]    byte_count_i,
  input  wire logic          last_word_i,
  // Output channel
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic      [63:0]   digest_first_o,
  output logic      [63:0]   digest_second_o,
  output logic      [63:0]   digest_third_o,
  output logic      [63:0]   digest_fourth_o
);

  sha256_pkg::state_e     state_q, state_d;
  sha256_pkg::core_ctrl_t ctrl;

  logic [3:0]   wcnt_q, wcnt_d;         // words held in the block window
  logic [5:0]   rnd_q, rnd_d;           // round index
  logic [60:0]  bytes_q, bytes_d;       // message length in bytes, wraps
  logic         final_q, final_d;       // padding of the current message is under way
  logic         mark_q, mark_d;         // the 0x80 pad word is still owed
  logic         len_hi_q, len_hi_d;     // the upper length word was just pushed
  logic         len_done_q, len_done_d; // the length word went into the last block
  logic         out_valid_q, out_valid_d;
  logic [255:0] digest_q, digest_d;

  logic [31:0]  push_word;
  logic [31:0]  sched_word;
  logic [255:0] chain_digest;
  logic [2:0]   cnt_eff;
  logic [31:0]  last_word_fmt;
  logic [63:0]  bit_len;
  logic         accept;
  logic         can_emit;

  assign in_stall_o = (state_q != sha256_pkg::StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign can_emit   = !out_valid_q || !out_stall_i;
  assign bit_len    = {bytes_q, 3'b000};

  // A short count only counts on the last beat, and counts above four mean four.
  assign cnt_eff = (!last_word_i || (byte_count_i > 3'd4)) ? 3'd4 : byte_count_i;

  // On a short last beat the pad byte takes the place of the first unused byte.
  always_comb begin
    case (cnt_eff)
      3'd0:    last_word_fmt = sha256_pkg::PadMarkWord;
      3'd1:    last_word_fmt = {data_word_i[31:24], sha256_pkg::PadByte, 16'h0000};
      3'd2:    last_word_fmt = {data_word_i[31:16], sha256_pkg::PadByte, 8'h00};
      3'd3:    last_word_fmt = {data_word_i[31:8], sha256_pkg::PadByte};
      default: last_word_fmt = data_word_i;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha256_pkg::StIdle: begin
        if (accept) begin
          if (wcnt_q == 4'd15) begin
            state_d = sha256_pkg::StRound;
          end else if (last_word_i) begin
            state_d = sha256_pkg::StPad;
          end
        end
      end
      sha256_pkg::StRound: begin
        if (rnd_q == 6'd63) begin
          state_d = sha256_pkg::StUpdate;
        end
      end
      sha256_pkg::StUpdate: begin
        if (len_done_q) begin
          state_d = sha256_pkg::StDigest;
        end else if (final_q) begin
          state_d = sha256_pkg::StPad;
        end else begin
          state_d = sha256_pkg::StIdle;
        end
      end
      sha256_pkg::StPad: begin
        if (wcnt_q == 4'd15) begin
          state_d = sha256_pkg::StRound;
        end
      end
      sha256_pkg::StDigest: begin
        if (can_emit) begin
          state_d = sha256_pkg::StIdle;
        end
      end
      default: state_d = sha256_pkg::StIdle;
    endcase
  end

  // Sequencer outputs and datapath register updates.
  always_comb begin
    ctrl        = '0;
    push_word   = '0;
    wcnt_d      = wcnt_q;
    rnd_d       = rnd_q;
    bytes_d     = bytes_q;
    final_d     = final_q;
    mark_d      = mark_q;
    len_hi_d    = len_hi_q;
    len_done_d  = len_done_q;
    out_valid_d = out_valid_q && out_stall_i;
    digest_d    = digest_q;
    unique case (state_q)
      sha256_pkg::StIdle: begin
        if (accept) begin
          ctrl.push = 1'b1;
          push_word = last_word_i ? last_word_fmt : data_word_i;
          wcnt_d    = wcnt_q + 4'd1;
          bytes_d   = bytes_q + {58'd0, cnt_eff};
          if (last_word_i) begin
            final_d = 1'b1;
            mark_d  = (cnt_eff == 3'd4);
          end
          if (wcnt_q == 4'd15) begin
            ctrl.load = 1'b1;
            rnd_d     = '0;
          end
        end
      end
      sha256_pkg::StRound: begin
        ctrl.step = 1'b1;
        rnd_d     = rnd_q + 6'd1;
      end
      sha256_pkg::StUpdate: begin
        ctrl.update = 1'b1;
      end
      sha256_pkg::StPad: begin
        // Order within the tail: the owed pad word, zeros, then the 64-bit bit length.
        // The lower length word follows only the upper one; when the pad ends at word
        // 14 or 15 the block is closed with zeros and the length goes into the next one.
        ctrl.push = 1'b1;
        wcnt_d    = wcnt_q + 4'd1;
        if (mark_q) begin
          push_word = sha256_pkg::PadMarkWord;
          mark_d    = 1'b0;
        end else if (wcnt_q == 4'd14) begin
          push_word = bit_len[63:32];
          len_hi_d  = 1'b1;
        end else if (len_hi_q) begin
          push_word  = bit_len[31:0];
          len_hi_d   = 1'b0;
          len_done_d = 1'b1;
        end else begin
          push_word = '0;
        end
        if (wcnt_q == 4'd15) begin
          ctrl.load = 1'b1;
          rnd_d     = '0;
        end
      end
      sha256_pkg::StDigest: begin
        if (can_emit) begin
          out_valid_d  = 1'b1;
          digest_d     = chain_digest;
          ctrl.restart = 1'b1;
          bytes_d      = '0;
          final_d      = 1'b0;
          mark_d       = 1'b0;
          len_hi_d     = 1'b0;
          len_done_d   = 1'b0;
        end
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha256_pkg::StIdle;
      wcnt_q      <= '0;
      rnd_q       <= '0;
      bytes_q     <= '0;
      final_q     <= 1'b0;
      mark_q      <= 1'b0;
      len_hi_q    <= 1'b0;
      len_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wcnt_q      <= wcnt_d;
      rnd_q       <= rnd_d;
      bytes_q     <= bytes_d;
      final_q     <= final_d;
      mark_q      <= mark_d;
      len_hi_q    <= len_hi_d;
      len_done_q  <= len_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The digest register holds a finished result so a new message can start.
  always_ff @(posedge clk_i) begin
    digest_q <= digest_d;
  end

  sha256_sched u_sched (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .push_word_i  (push_word),
    .sched_word_o (sched_word)
  );

  sha256_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .round_k_i    (sha256_pkg::RoundK[rnd_q]),
    .sched_word_i (sched_word),
    .digest_o     (chain_digest)
  );

  assign out_valid_o     = out_valid_q;
  assign digest_first_o  = digest_q[255:192];
  assign digest_second_o = digest_q[191:128];
  assign digest_third_o  = digest_q[127:64];
  assign digest_fourth_o = digest_q[63:0];

endmodule
`default_nettype wire

// ===== sim/tb_sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds messages as 32-bit beats and checks every digest against a SHA-256
// model kept in a small scoreboard. A short directed run covers the edge cases
// of the byte count. A long random run follows with bursty input and a
// stalling receiver, including one long hold-off.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;

  localparam int          HALF_PERIOD      = 5;
  localparam int unsigned BULK_BEATS       = 1250;
  localparam int unsigned LONG_HOLD_CYCLES = 1500;
  localparam int unsigned WATCHDOG_LIMIT   = 10000;
  localparam int unsigned DRAIN_CYCLES     = 300;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam bit [31:0]   PAD_WORD         = 32'h8000_0000;

  localparam bit [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam bit [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_e;

  // Tracks the hash of the message in flight and holds the digests that are
  // still owed by the block, oldest first.
  class digest_scoreboard;
    bit [31:0]   chain [8];
    bit [31:0]   blk [16];
    int unsigned fill;
    bit [60:0]   msg_bytes;
    bit [255:0]  pending [$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      chain     = SHA_IV;
      fill      = 0;
      msg_bytes = '0;
    endfunction

    function bit [31:0] ror(bit [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress_block();
      bit [31:0] w [64];
      bit [31:0] v [8];
      bit [31:0] s0, s1, t1, t2;
      for (int t = 0; t < 16; t++) w[t] = blk[t];
      for (int t = 16; t < 64; t++) begin
        s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      v = chain;
      for (int t = 0; t < 64; t++) begin
        s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
        t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
        s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
        t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int t = 0; t < 8; t++) chain[t] += v[t];
    endfunction

    function void push_word(bit [31:0] w);
      blk[fill] = w;
      fill = (fill + 1) % 16;
      if (fill == 0) compress_block();
    endfunction

    // Called for every accepted input beat.
    function void note_beat(bit [31:0] data, bit [2:0] count, bit last);
      int unsigned n;
      bit [31:0]   keep;
      bit [63:0]   bit_len;
      // Only the last beat may be short; a count above four means a full word.
      n = (count > 4 || !last) ? 4 : count;
      msg_bytes += n;
      if (!last) begin
        push_word(data);
        return;
      end
      if (n == 4) begin
        push_word(data);
        push_word(PAD_WORD);
      end else begin
        // Bytes past the count are dropped and the pad byte takes their place.
        keep = (n == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * n));
        push_word((data & keep) | (32'h80 << (24 - 8 * n)));
      end
      while (fill != 14) push_word(32'h0);
      bit_len = {msg_bytes, 3'b000};
      push_word(bit_len[63:32]);
      push_word(bit_len[31:0]);
      pending.push_back({chain[0], chain[1], chain[2], chain[3],
                         chain[4], chain[5], chain[6], chain[7]});
      restart();
    endfunction

    // Called for every accepted output beat.
    function void check_digest(logic [63:0] first, logic [63:0] second,
                               logic [63:0] third, logic [63:0] fourth);
      bit [255:0]  want;
      logic [63:0] got [4];
      got = '{first, second, third, fourth};
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: digest with none outstanding: %h %h %h %h",
                   $time, first, second, third, fourth);
        return;
      end
      want = pending.pop_front();
      for (int k = 0; k < 4; k++) begin
        if (got[k] !== want[255 - 64 * k -: 64]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: digest part %0d: expected %h, actual %h",
                     $time, k, want[255 - 64 * k -: 64], got[k]);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] data_word_i;
  logic [2:0]  byte_count_i;
  logic        last_word_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] digest_first_o;
  logic [63:0] digest_second_o;
  logic [63:0] digest_third_o;
  logic [63:0] digest_fourth_o;

  digest_scoreboard board;
  int unsigned      beats_sent;
  int unsigned      burst_left;
  int unsigned      idle_cycles;
  bit               bulk_phase;
  bit               long_hold_done;

  sha256_stream_hasher uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_word_i     (data_word_i),
    .byte_count_i    (byte_count_i),
    .last_word_i     (last_word_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .digest_first_o  (digest_first_o),
    .digest_second_o (digest_second_o),
    .digest_third_o  (digest_third_o),
    .digest_fourth_o (digest_fourth_o)
  );

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // Offers one beat and returns at the edge where it is taken. Must be
  // entered right after a rising edge.
  task automatic send_beat(input bit [31:0] data, input bit [2:0] count, input bit last);
    in_valid_i   <= 1'b1;
    data_word_i  <= data;
    byte_count_i <= count;
    last_word_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drops valid for a while; the payload is scrambled so that nothing
  // downstream can lean on it.
  task automatic pause_sender(input int unsigned cycles);
    in_valid_i   <= 1'b0;
    data_word_i  <= $urandom;
    byte_count_i <= $urandom_range(0, 7);
    last_word_i  <= $urandom_range(0, 1);
    repeat (cycles) @(posedge clk_i);
  endtask

  // One message of random length. Lengths cluster around the points where the
  // padding spills into an extra block (14 and 16 words, then 30 and 32).
  task automatic send_random_message();
    int unsigned nwords;
    bit [31:0]   data;
    bit [2:0]    count;
    bit          last;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: nwords = $urandom_range(1, 6);
      4, 5, 6:    nwords = $urandom_range(12, 18);
      7, 8:       nwords = $urandom_range(28, 34);
      default:    nwords = $urandom_range(1, 48);
    endcase
    for (int unsigned i = 0; i < nwords; i++) begin
      case ($urandom_range(0, 9))
        0:       data = 32'h0000_0000;
        1:       data = 32'hFFFF_FFFF;
        default: data = $urandom;
      endcase
      last = (i == nwords - 1);
      // Inner beats mostly carry four, but any count must be read as four.
      if (last || $urandom_range(0, 3) == 0) count = $urandom_range(0, 7);
      else count = 3'd4;
      send_beat(data, count, last);
      beats_sent++;
      if (burst_left == 0) begin
        pause_sender($urandom_range(1, 8));
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Monitor and watchdog: both channels are sampled at the rising edge, before
  // any of this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        board.note_beat(data_word_i, byte_count_i, last_word_i);
      if (out_valid_o && !out_stall_i)
        board.check_digest(digest_first_o, digest_second_o, digest_third_o,
                           digest_fourth_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: stretches of differing stall density. Once the random run is
  // under way it also holds off for a long stretch so that the block fills
  // and pushes back on the sender.
  initial begin
    stall_mode_e mode;
    int unsigned span;
    out_stall_i    = 1'b0;
    long_hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HALF:  out_stall_i <= $urandom_range(0, 1);
          default:     out_stall_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
      if (bulk_phase && !long_hold_done) begin
        @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold_done = 1'b1;
      end
    end
  end

  initial begin
    board        = new();
    beats_sent   = 0;
    burst_left   = 0;
    idle_cycles  = 0;
    bulk_phase   = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_word_i  = '0;
    byte_count_i = '0;
    last_word_i  = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats, back to back.
    // Empty message: a last beat with no bytes, its word must be ignored.
    send_beat(32'hFFFF_FFFF, 3'd0, 1'b1);
    // Three bytes, with a junk byte that the pad has to replace.
    send_beat(32'h6162_63FF, 3'd3, 1'b1);
    send_beat(32'h0000_0000, 3'd4, 1'b1);
    send_beat(32'hFFFF_FFFF, 3'd1, 1'b1);
    send_beat(32'h8000_0000, 3'd2, 1'b1);
    // A count above four on the last beat reads as four.
    send_beat(32'h1234_5678, 3'd7, 1'b1);
    // Short counts on inner beats read as four.
    send_beat(32'hFFFF_FFFF, 3'd0, 1'b0);
    send_beat(32'h0000_0000, 3'd5, 1'b1);
    send_beat(32'hA5A5_A5A5, 3'd6, 1'b0);
    send_beat(32'h5A5A_5A5A, 3'd2, 1'b0);
    send_beat(32'hDEAD_BEEF, 3'd3, 1'b1);
    pause_sender(5);

    bulk_phase = 1'b1;
    burst_left = $urandom_range(1, 10);
    while (beats_sent < BULK_BEATS) send_random_message();
    in_valid_i <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.pending.size() != 0)
      $display("%0d digests never arrived", board.pending.size());
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
